/* design/assert_macros.svh */
// Assertion helpers used by the frame tracker module arc_frame.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ARC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ARC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* design/arc_pkg.sv */
`default_nettype none

package arc_pkg;

  // Frame buffer capacity default and fixed keyword window geometry.
  localparam int BufferBytesDef = 100;
  localparam int KwCount        = 15;
  localparam int WinDepth       = 19;
  localparam int KwBits         = WinDepth * 8;
  localparam int KwDtmf         = 1;

  // Beat kinds on the input channel.
  localparam logic KindByte    = 1'b0;
  localparam logic KindTimeout = 1'b1;

  // Event codes.
  localparam logic [3:0] EvNone       = 4'd0;
  localparam logic [3:0] EvRing       = 4'd1;
  localparam logic [3:0] EvDtmf       = 4'd2;
  localparam logic [3:0] EvSignal     = 4'd3;
  localparam logic [3:0] EvSms        = 4'd4;
  localparam logic [3:0] EvConnected  = 4'd5;
  localparam logic [3:0] EvCallEnd    = 4'd6;
  localparam logic [3:0] EvSmsSent    = 4'd7;
  localparam logic [3:0] EvOperator   = 4'd8;
  localparam logic [3:0] EvBusy       = 4'd9;
  localparam logic [3:0] EvSimRemoved = 4'd10;
  localparam logic [3:0] EvSimReady   = 4'd11;

  typedef logic [KwBits-1:0] kw_text_t;
  typedef logic [4:0]        kw_len_t;
  typedef logic [3:0]        event_t;

  // Window of recent bytes; entry 0 holds the newest byte.
  typedef logic [WinDepth-1:0][7:0] window_t;

  // Keyword text, right aligned: byte 0 is the last character.
  localparam kw_text_t KwText [KwCount] = '{
    KwBits'("+CLIP:"),
    KwBits'("+DTMF: "),
    KwBits'("+CSQ:"),
    KwBits'("+CPIN: READY"),
    KwBits'("+CMT:"),
    KwBits'("MO CONNECTED"),
    KwBits'("NO CARRIER"),
    KwBits'("+CMGS:"),
    KwBits'("+COPS: 0,0,"),
    KwBits'("BUSY"),
    KwBits'("NO ANSWER"),
    KwBits'("+CPIN: NOT READY"),
    KwBits'("+CPIN: NOT INSERTED"),
    KwBits'("Call Ready"),
    KwBits'("SMS Ready")
  };

  localparam kw_len_t KwLen [KwCount] = '{
    5'd6, 5'd7, 5'd5, 5'd12, 5'd5, 5'd12, 5'd10, 5'd6,
    5'd11, 5'd4, 5'd9, 5'd16, 5'd19, 5'd10, 5'd9
  };

  localparam event_t EventOfKw [KwCount] = '{
    EvRing, EvDtmf, EvSignal, EvSimReady, EvSms, EvConnected, EvCallEnd,
    EvSmsSent, EvOperator, EvBusy, EvBusy, EvSimRemoved, EvSimRemoved,
    EvSimReady, EvSimReady
  };

  // Registered input beat handed to the frame tracker.
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] rx_byte;
  } arc_beat_t;

  // Classification of the closing frame.
  typedef struct packed {
    event_t     event_code;
    logic [7:0] dtmf_char;
  } arc_class_t;

endpackage

`default_nettype wire

/* design/arc_kw_match.sv */
`default_nettype none

module arc_kw_match (
  input  wire arc_pkg::window_t              window_nxt,
  input  wire logic [arc_pkg::KwCount-1:0]   seen,
  input  wire logic [7:0]                    dtmf_byte,
  output logic      [arc_pkg::KwCount-1:0]   hit,
  output arc_pkg::arc_class_t                cls
);

  // Compare the tail of the shifted window against every keyword in parallel.
  always_comb begin
    for (int k = 0; k < arc_pkg::KwCount; k++) begin
      hit[k] = 1'b1;
      for (int i = 0; i < arc_pkg::WinDepth; i++) begin
        if ((5'(i) < arc_pkg::KwLen[k]) &&
            (window_nxt[i] != arc_pkg::KwText[k][8*i +: 8])) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  // The highest-indexed keyword seen in the frame selects the event.
  always_comb begin
    cls.event_code = arc_pkg::EvNone;
    cls.dtmf_char  = 8'd0;
    for (int k = 0; k < arc_pkg::KwCount; k++) begin
      if (seen[k]) begin
        cls.event_code = arc_pkg::EventOfKw[k];
        cls.dtmf_char  = (k == arc_pkg::KwDtmf) ? dtmf_byte : 8'd0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/arc_frame.sv */
`default_nettype none
`include "assert_macros.svh"

module arc_frame #(
  parameter int BUFFER_BYTES = arc_pkg::BufferBytesDef
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire arc_pkg::arc_beat_t  beat,
  output logic                     adv,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic [3:0]               out_event_code,
  output logic [7:0]               out_dtmf_char,
  output logic                     out_overflowed,
  output logic [6:0]               out_frame_length
);

  localparam int CntRaw = $clog2(BUFFER_BYTES + 1);
  localparam int CntW   = (CntRaw > 7) ? CntRaw : 7;

  arc_pkg::window_t                window_r;
  arc_pkg::window_t                window_nxt;
  logic [arc_pkg::KwCount-1:0]     seen_r;
  logic [arc_pkg::KwCount-1:0]     seen_nxt;
  logic [arc_pkg::KwCount-1:0]     hit;
  logic [CntW-1:0]                 count_r;
  logic                            ovf_r;
  logic                            pend_r;
  logic                            pend_nxt;
  logic [7:0]                      dbyte_r;
  logic [7:0]                      dbyte_nxt;
  arc_pkg::arc_class_t             cls;
  logic                            timeout;
  logic                            take_byte;
  logic                            drop_byte;
  logic                            room;

  logic                            out_valid_r;
  logic [3:0]                      out_event_code_r;
  logic [7:0]                      out_dtmf_char_r;
  logic                            out_overflowed_r;
  logic [6:0]                      out_frame_length_r;

  // A byte beat always moves on; a timeout beat needs a free result register.
  assign adv = beat.valid &&
               ((beat.kind == arc_pkg::KindByte) || !out_valid_r || !out_stall);

  assign room      = (count_r < CntW'(BUFFER_BYTES));
  assign timeout   = adv && (beat.kind == arc_pkg::KindTimeout);
  assign take_byte = adv && (beat.kind == arc_pkg::KindByte) && room;
  assign drop_byte = adv && (beat.kind == arc_pkg::KindByte) && !room;

  // Shift the new byte into the newest slot of the window.
  assign window_nxt = {window_r[arc_pkg::WinDepth-2:0], beat.rx_byte};

  arc_kw_match u_match (
    .window_nxt (window_nxt),
    .seen       (seen_r),
    .dtmf_byte  (dbyte_r),
    .hit        (hit),
    .cls        (cls)
  );

  // Keyword flags and the capture of the byte after the first DTMF keyword.
  always_comb begin
    seen_nxt  = seen_r | hit;
    pend_nxt  = pend_r;
    dbyte_nxt = dbyte_r;
    if (pend_r) begin
      dbyte_nxt = beat.rx_byte;
      pend_nxt  = 1'b0;
    end
    if (hit[arc_pkg::KwDtmf] && !seen_r[arc_pkg::KwDtmf]) begin
      pend_nxt = 1'b1;
    end
  end

  // Frame state: cleared at reset and whenever a timeout closes the frame.
  always_ff @(posedge clk) begin
    if (!rst_n || timeout) begin
      window_r <= '0;
      seen_r   <= '0;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      pend_r   <= 1'b0;
      dbyte_r  <= 8'd0;
    end else if (take_byte) begin
      window_r <= window_nxt;
      seen_r   <= seen_nxt;
      count_r  <= count_r + 1'b1;
      pend_r   <= pend_nxt;
      dbyte_r  <= dbyte_nxt;
    end else if (drop_byte) begin
      ovf_r    <= 1'b1;
    end
  end

  // Result register: loaded on a timeout, released when the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (timeout) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (timeout) begin
      out_event_code_r   <= cls.event_code;
      out_dtmf_char_r    <= cls.dtmf_char;
      out_overflowed_r   <= ovf_r;
      out_frame_length_r <= count_r[6:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_code   = out_event_code_r;
  assign out_dtmf_char    = out_dtmf_char_r;
  assign out_overflowed   = out_overflowed_r;
  assign out_frame_length = out_frame_length_r;

  // Consistency checks on the frame state and the result.
  `ARC_ASSERT(a_count_bound, count_r <= CntW'(BUFFER_BYTES), "frame count beyond capacity")
  `ARC_ASSERT_IMP(a_ovf_full, ovf_r, count_r == CntW'(BUFFER_BYTES), "overflow before full")
  `ARC_ASSERT_IMP(a_pend_seen, pend_r, seen_r[arc_pkg::KwDtmf], "capture without keyword")
  `ARC_ASSERT_IMP(a_dchar_dtmf, out_valid_r && (out_dtmf_char_r != 8'd0), out_event_code_r == arc_pkg::EvDtmf, "dtmf char on other event")
  `ARC_ASSERT(a_rearm, timeout |=> (count_r == '0 && seen_r == '0 && !ovf_r), "frame not rearmed")

endmodule

`default_nettype wire

/* design/at_response_classifier_top.sv */
// A timeout beat passes the input register, then loads the out_valid register.
// Throughput: one beat per cycle; a byte beat waits only behind a timeout beat
// whose result register is still held by out_stall.
// Reset (rst_n low, synchronous) empties the input stage and the result register
// and clears the frame: window, keyword flags, count, overflow and DTMF capture.
`default_nettype none

module at_response_classifier_top #(
  parameter int BUFFER_BYTES = arc_pkg::BufferBytesDef
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_kind,
  input  wire [7:0]  in_rx_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [3:0] out_event_code,
  output logic [7:0] out_dtmf_char,
  output logic       out_overflowed,
  output logic [6:0] out_frame_length
);

  arc_pkg::arc_beat_t beat_r;
  logic               adv;

  // Input register holds its beat until the frame tracker takes it.
  assign in_stall = beat_r.valid && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (!in_stall) begin
      beat_r.valid   <= in_valid;
      beat_r.kind    <= in_kind;
      beat_r.rx_byte <= in_rx_byte;
    end
  end

  arc_frame #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_frame (
    .clk              (clk),
    .rst_n            (rst_n),
    .beat             (beat_r),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_code   (out_event_code),
    .out_dtmf_char    (out_dtmf_char),
    .out_overflowed   (out_overflowed),
    .out_frame_length (out_frame_length)
  );

endmodule

`default_nettype wire

/* bench/at_response_classifier_top_tb.sv */
`default_nettype none

module at_response_classifier_top_tb;

  localparam int FrameCap = arc_pkg::BufferBytesDef;
  localparam int DrainLimit = 20000;

  // One classification as it should leave the result channel.
  typedef struct {
    arc_pkg::event_t event_code;
    logic [7:0]      dtmf_char;
    logic            overflowed;
    logic [6:0]      frame_length;
  } frame_class_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_kind;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] out_event_code;
  logic [7:0] out_dtmf_char;
  logic       out_overflowed;
  logic [6:0] out_frame_length;

  at_response_classifier_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_code  (out_event_code),
    .out_dtmf_char   (out_dtmf_char),
    .out_overflowed  (out_overflowed),
    .out_frame_length(out_frame_length)
  );

  // Response keywords in priority order; a higher index wins.
  string kw_text [arc_pkg::KwCount] = '{
    "+CLIP:", "+DTMF: ", "+CSQ:", "+CPIN: READY", "+CMT:", "MO CONNECTED",
    "NO CARRIER", "+CMGS:", "+COPS: 0,0,", "BUSY", "NO ANSWER",
    "+CPIN: NOT READY", "+CPIN: NOT INSERTED", "Call Ready", "SMS Ready"
  };
  arc_pkg::event_t kw_event [arc_pkg::KwCount] = '{
    arc_pkg::EvRing, arc_pkg::EvDtmf, arc_pkg::EvSignal, arc_pkg::EvSimReady,
    arc_pkg::EvSms, arc_pkg::EvConnected, arc_pkg::EvCallEnd, arc_pkg::EvSmsSent,
    arc_pkg::EvOperator, arc_pkg::EvBusy, arc_pkg::EvBusy, arc_pkg::EvSimRemoved,
    arc_pkg::EvSimRemoved, arc_pkg::EvSimReady, arc_pkg::EvSimReady
  };

  // Frame state as the block should hold it; entry 0 is the newest byte.
  logic [7:0]                  recent [arc_pkg::WinDepth];
  logic [arc_pkg::KwCount-1:0] kw_seen;
  int                          taken_count;
  logic                        dropped_any;
  logic                        dtmf_armed;
  logic [7:0]                  dtmf_held;

  frame_class_t awaited_classes [$];
  logic [7:0]   frame_bytes [$];

  int  errors;
  int  beats_sent;
  int  frames_sent;
  int  results_seen;
  int  overflow_results;
  int  event_hits [16];
  bit  quiet;
  int  stall_left;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #1000000;
    $display("at_response_classifier_top verification failed");
    $finish;
  end

  function automatic void clear_frame_state();
    int i;
    for (i = 0; i < arc_pkg::WinDepth; i++) recent[i] = 8'h00;
    kw_seen = '0;
    taken_count = 0;
    dropped_any = 1'b0;
    dtmf_armed = 1'b0;
    dtmf_held = 8'h00;
  endfunction

  function automatic bit window_ends_with(int k);
    int n;
    int i;
    n = kw_text[k].len();
    if (taken_count < n) return 1'b0;
    for (i = 0; i < n; i++) begin
      if (recent[n - 1 - i] != kw_text[k][i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Shift one accepted byte into the window and update the keyword flags.
  function automatic void take_rx_byte(logic [7:0] rx);
    int i;
    int k;
    for (i = arc_pkg::WinDepth - 1; i > 0; i--) recent[i] = recent[i - 1];
    recent[0] = rx;
    taken_count++;
    if (dtmf_armed) begin
      dtmf_held = rx;
      dtmf_armed = 1'b0;
    end
    for (k = 0; k < arc_pkg::KwCount; k++) begin
      if (window_ends_with(k)) begin
        if (k == arc_pkg::KwDtmf && !kw_seen[arc_pkg::KwDtmf]) dtmf_armed = 1'b1;
        kw_seen[k] = 1'b1;
      end
    end
  endfunction

  // Closing timeout: the highest keyword seen picks the event.
  function automatic frame_class_t classify_frame();
    frame_class_t c;
    int k;
    c.event_code = arc_pkg::EvNone;
    c.dtmf_char = 8'h00;
    c.overflowed = dropped_any;
    c.frame_length = taken_count[6:0];
    for (k = arc_pkg::KwCount - 1; k >= 0; k--) begin
      if (kw_seen[k]) begin
        c.event_code = kw_event[k];
        if (k == arc_pkg::KwDtmf) c.dtmf_char = dtmf_held;
        break;
      end
    end
    clear_frame_state();
    return c;
  endfunction

  // Receiver side: random stall bursts unless the run is in its quiet part.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (quiet) stall_left = 0;
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 11);
      end
    end
  end

  // Compare every accepted result with the oldest classification waiting.
  always @(posedge clk) begin : check_results
    frame_class_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_classes.size() == 0) begin
        $error("result with no closed frame: event_code %0d", out_event_code);
        errors++;
      end else begin
        want = awaited_classes.pop_front();
        if (out_event_code !== want.event_code) begin
          $error("event_code: expected %0d, got %0d", want.event_code, out_event_code);
          errors++;
        end
        if (out_dtmf_char !== want.dtmf_char) begin
          $error("dtmf_char: expected %0d, got %0d", want.dtmf_char, out_dtmf_char);
          errors++;
        end
        if (out_overflowed !== want.overflowed) begin
          $error("overflowed: expected %0d, got %0d", want.overflowed, out_overflowed);
          errors++;
        end
        if (out_frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length,
                 out_frame_length);
          errors++;
        end
        results_seen++;
        event_hits[want.event_code]++;
        if (want.overflowed) overflow_results++;
      end
    end
  end

  // Send one beat, with an occasional idle burst ahead of it.
  task automatic send_beat(logic kind, logic [7:0] rx);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_kind = kind;
    in_rx_byte = rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (kind == arc_pkg::KindByte) begin
      if (taken_count < FrameCap) take_rx_byte(rx);
      else dropped_any = 1'b1;
    end else begin
      awaited_classes.push_back(classify_frame());
    end
  endtask

  task automatic add_chars(string s, int n);
    int i;
    for (i = 0; i < n; i++) frame_bytes.push_back(s[i]);
  endtask

  task automatic add_text(string s);
    add_chars(s, s.len());
  endtask

  task automatic add_noise(int n);
    repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Send the collected bytes and close the frame with a timeout beat.
  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++) send_beat(arc_pkg::KindByte, frame_bytes[i]);
    send_beat(arc_pkg::KindTimeout, 8'($urandom_range(0, 255)));
    frame_bytes.delete();
    frames_sent++;
  endtask

  // Lower valid and wait until every closed frame has been classified.
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_classes.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_classes.size() != 0) begin
      $error("%0d results never arrived", awaited_classes.size());
      errors++;
    end
  endtask

  // A random frame: mostly well-formed responses, some noise, broken text, empty and long frames.
  task automatic build_random_frame();
    int segs;
    int k;
    case ($urandom_range(0, 19))
      0: add_noise($urandom_range(1, 12));
      1: ;
      2: begin
        // Long frame that ends near or past the end of the buffer.
        add_noise($urandom_range(0, 10));
        add_text(kw_text[$urandom_range(0, arc_pkg::KwCount - 1)]);
        add_noise(FrameCap - frame_bytes.size() + int'($urandom_range(0, 12)) - 6);
        add_text(kw_text[$urandom_range(0, arc_pkg::KwCount - 1)]);
        frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        add_noise($urandom_range(0, 3));
        segs = $urandom_range(1, 3);
        repeat (segs) begin
          k = $urandom_range(0, arc_pkg::KwCount - 1);
          if ($urandom_range(0, 4) == 0) begin
            add_chars(kw_text[k], $urandom_range(1, kw_text[k].len() - 1));
          end else begin
            add_text(kw_text[k]);
          end
          if (k == arc_pkg::KwDtmf && $urandom_range(0, 3) != 0) begin
            frame_bytes.push_back(8'($urandom_range(0, 255)));
          end
          if ($urandom_range(0, 1) == 0) add_text("\r\n");
        end
      end
    endcase
  endtask

  // Every keyword, DTMF capture corners, zero bytes, priority and overflow.
  task automatic test_directed();
    int k;
    send_frame();
    for (k = 0; k < arc_pkg::KwCount; k++) begin
      add_text("\r\n");
      add_text(kw_text[k]);
      if (k == arc_pkg::KwDtmf) add_text("7");
      add_text("\r\n");
      send_frame();
    end
    add_text("+DTMF: ");
    send_frame();
    add_text("+DTMF: 3\r\n+DTMF: 9");
    send_frame();
    frame_bytes.push_back(8'h00);
    add_text("BUSY");
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    send_frame();
    add_text("BU");
    frame_bytes.push_back(8'h00);
    add_text("SY");
    send_frame();
    add_text("+CLIP: 1\r\n+CMGS: 4\r\nBUSY\r\n");
    send_frame();
    add_text("SMS Ready\r\n+CLIP: 2");
    send_frame();
    // Keyword inside the buffer, a higher one in the dropped tail.
    add_text("NO CARRIER");
    repeat (FrameCap - 10) frame_bytes.push_back(8'($urandom_range(128, 255)));
    add_text("Call Ready");
    send_frame();
    // DTMF keyword fills the buffer; its character is dropped.
    repeat (FrameCap - 7) frame_bytes.push_back(8'($urandom_range(128, 255)));
    add_text("+DTMF: 5");
    send_frame();
  endtask

  task automatic test_random_frames(int beats);
    int stop_at;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      build_random_frame();
      send_frame();
    end
  endtask

  // The sender holds off until the result channel has caught up.
  task automatic test_sender_pause();
    repeat (2) begin
      build_random_frame();
      send_frame();
      drain_results();
    end
  endtask

  task automatic test_back_to_back(int beats);
    quiet = 1'b1;
    test_random_frames(beats);
  endtask

  initial begin
    int i;
    int kinds_hit;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = arc_pkg::KindByte;
    in_rx_byte = 8'h00;
    quiet = 1'b0;
    errors = 0;
    beats_sent = 0;
    frames_sent = 0;
    results_seen = 0;
    overflow_results = 0;
    for (i = 0; i < 16; i++) event_hits[i] = 0;
    clear_frame_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_frames(40);
    test_sender_pause();
    test_random_frames(20);
    test_back_to_back(40);

    drain_results();
    repeat (6) @(posedge clk);
    if (awaited_classes.size() != 0) begin
      $error("%0d classifications left over", awaited_classes.size());
      errors++;
    end

    kinds_hit = 0;
    for (i = 0; i < 16; i++) if (event_hits[i] != 0) kinds_hit++;
    $display("Sent %0d beats in %0d frames; %0d results checked, %0d with overflow.",
             beats_sent, frames_sent, results_seen, overflow_results);
    $display("%0d distinct event codes seen; %0d mismatches.", kinds_hit, errors);
    if (errors == 0) begin
      $display("at_response_classifier_top verification clean");
    end else begin
      $display("at_response_classifier_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/arc_pkg.sv
design/arc_kw_match.sv
design/arc_frame.sv
design/at_response_classifier_top.sv
bench/at_response_classifier_top_tb.sv
